/* hw/rtl/rau_pkg.sv */
// ----------------------------------------------------------------------------
// rau_pkg
// Shared types and constants of the rational arithmetic unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rau_pkg;

    localparam int OPERAND_WIDTH_DEF = 16;

    localparam int OP_W     = 3;
    localparam int STATUS_W = 2;
    localparam int NUM_W    = 32;
    localparam int DEN_W    = 31;
    localparam int OUT_BITS = NUM_W + DEN_W + 1 + STATUS_W;
    localparam int OUT_TW   = ((OUT_BITS + 7) / 8) * 8;

    localparam logic [OP_W-1:0] OP_ADD = 3'd0;
    localparam logic [OP_W-1:0] OP_SUB = 3'd1;
    localparam logic [OP_W-1:0] OP_MUL = 3'd2;
    localparam logic [OP_W-1:0] OP_DIV = 3'd3;
    localparam logic [OP_W-1:0] OP_GT  = 3'd4;
    localparam logic [OP_W-1:0] OP_LT  = 3'd5;

    localparam logic [STATUS_W-1:0] STATUS_OK       = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_INVALID  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_OVERFLOW = 2'd2;

    // controller states; compute states double as datapath step codes
    typedef enum logic [4:0] {
        ST_IDLE, ST_DECODE,
        ST_G1, ST_Q1, ST_Q2, ST_T1, ST_T2, ST_TL, ST_COMB,
        ST_P1, ST_P2, ST_C1, ST_C2,
        ST_ZCHK, ST_RG, ST_RN, ST_RD, ST_OUT
    } state_t;

    typedef enum logic [1:0] {
        ENG_MUL, ENG_DIV, ENG_GCD
    } eng_mode_t;

    typedef struct packed {
        logic   load_in;
        logic   start;
        state_t step;
        logic   comb;
        logic   load_out;
    } cmd_t;

    typedef struct packed {
        logic eng_done;
        logic is_cmp;
        logic is_addsub;
        logic invalid;
        logic zero;
    } stat_t;

endpackage

`default_nettype wire

/* hw/rtl/rau_ctrl.sv */
// ----------------------------------------------------------------------------
// rau_ctrl
// Sequencer: steps the datapath through each operation's program.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_ctrl
    import rau_pkg::*;
(
    input  wire logic  aclk,
    input  wire logic  aresetn,
    input  wire logic  s_tvalid,
    output logic       s_tready,
    output logic       m_tvalid,
    input  wire logic  m_tready,
    output cmd_t       cmd,
    input  wire stat_t stat
);

    state_t state_reg, state_next;
    logic   issued_reg, issued_next;
    logic   m_valid_reg, m_valid_next;
    logic   is_compute;
    state_t succ;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            issued_reg  <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            issued_reg  <= issued_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_comb begin
        is_compute = 1'b1;
        succ       = ST_IDLE;
        case (state_reg)
            ST_G1:   succ = ST_Q1;
            ST_Q1:   succ = ST_Q2;
            ST_Q2:   succ = ST_T1;
            ST_T1:   succ = ST_T2;
            ST_T2:   succ = ST_TL;
            ST_TL:   succ = ST_COMB;
            ST_P1:   succ = ST_P2;
            ST_P2:   succ = ST_ZCHK;
            ST_C1:   succ = ST_C2;
            ST_C2:   succ = ST_OUT;
            ST_RG:   succ = ST_RN;
            ST_RN:   succ = ST_RD;
            ST_RD:   succ = ST_OUT;
            default: is_compute = 1'b0;
        endcase
    end

    always_comb begin
        state_next   = state_reg;
        issued_next  = issued_reg;
        cmd          = '0;
        cmd.step     = state_reg;
        if (is_compute) begin
            if (!issued_reg) begin
                cmd.start   = 1'b1;
                issued_next = 1'b1;
            end else if (stat.eng_done) begin
                issued_next = 1'b0;
                state_next  = succ;
            end
        end else begin
            case (state_reg)
                ST_IDLE: begin
                    if (s_tvalid) begin
                        cmd.load_in = 1'b1;
                        state_next  = ST_DECODE;
                    end
                end
                ST_DECODE: begin
                    if (stat.is_cmp)         state_next = ST_C1;
                    else if (stat.invalid)   state_next = ST_OUT;
                    else if (stat.is_addsub) state_next = ST_G1;
                    else                     state_next = ST_P1;
                end
                ST_COMB: begin
                    cmd.comb   = 1'b1;
                    state_next = ST_ZCHK;
                end
                ST_ZCHK: begin
                    state_next = stat.zero ? ST_OUT : ST_RG;
                end
                ST_OUT: begin
                    if (!m_valid_reg || m_tready) begin
                        cmd.load_out = 1'b1;
                        state_next   = ST_IDLE;
                    end
                end
                default: state_next = ST_IDLE;
            endcase
        end
        m_valid_next = cmd.load_out ? 1'b1 : (m_tready ? 1'b0 : m_valid_reg);
    end

    assign s_tready = (state_reg == ST_IDLE);
    assign m_tvalid = m_valid_reg;

endmodule

`default_nettype wire

/* hw/rtl/rau_dp.sv */
// ----------------------------------------------------------------------------
// rau_dp
// Datapath: operand registers, shared iterative mul/div/gcd engine, result.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_dp
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF
) (
    input  wire logic                     aclk,
    input  wire logic                     aresetn,
    input  wire cmd_t                     cmd,
    output stat_t                         stat,
    input  wire logic [OP_W-1:0]          in_op,
    input  wire logic [OPERAND_WIDTH-1:0] in_a,
    input  wire logic [OPERAND_WIDTH-1:0] in_b,
    input  wire logic [OPERAND_WIDTH-1:0] in_c,
    input  wire logic [OPERAND_WIDTH-1:0] in_d,
    output logic [NUM_W-1:0]              out_num,
    output logic [DEN_W-1:0]              out_den,
    output logic                          out_cmp,
    output logic [STATUS_W-1:0]           out_status
);

    localparam int W  = OPERAND_WIDTH;
    localparam int M  = W + 1;
    localparam int X  = 2 * W + 2;
    localparam int CW = $clog2(X + 1);
    localparam int LW = (X > 33) ? X : 33;

    logic [OP_W-1:0] op_reg;
    logic            sa_reg, sb_reg, sc_reg, sd_reg, neg_reg;
    logic [X-1:0]    ra_reg, rb_reg, rc_reg, rd_reg, rg_reg, rp_reg, rq_reg;

    logic            eng_busy_reg;
    eng_mode_t       eng_mode_reg, mode_sel;
    state_t          step_reg;
    logic [X-1:0]    x_reg, y_reg, x_next, y_next, opa, opb, eng_res;
    logic [X:0]      acc_reg, acc_next, rem_sh;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic            eng_done, ge;

    logic [M-1:0]    am, bm, cm, dm;
    logic            is_cmp, inv_in;

    function automatic logic [M-1:0] mag(input logic [W-1:0] v);
        logic [M-1:0] e;
        e = {v[W-1], v};
        return v[W-1] ? (~e + M'(1)) : e;
    endfunction

    assign am = mag(in_a);
    assign bm = mag(in_b);
    assign cm = mag(in_c);
    assign dm = mag(in_d);

    assign is_cmp = (op_reg == OP_GT) || (op_reg == OP_LT);

    // operand and unit selection per step
    always_comb begin
        mode_sel = ENG_MUL;
        opa      = ra_reg;
        opb      = rc_reg;
        case (cmd.step)
            ST_G1: begin mode_sel = ENG_GCD; opa = rb_reg; opb = rd_reg; end
            ST_Q1: begin mode_sel = ENG_DIV; opa = rd_reg; opb = rg_reg; end
            ST_Q2: begin mode_sel = ENG_DIV; opa = rb_reg; opb = rg_reg; end
            ST_T1: begin opa = rp_reg; opb = ra_reg; end
            ST_T2: begin opa = rq_reg; opb = rc_reg; end
            ST_TL: begin opa = rq_reg; opb = rd_reg; end
            ST_P1: begin opa = ra_reg; opb = (op_reg == OP_DIV) ? rd_reg : rc_reg; end
            ST_P2: begin opa = rb_reg; opb = (op_reg == OP_DIV) ? rc_reg : rd_reg; end
            ST_C1: begin opa = ra_reg; opb = rd_reg; end
            ST_C2: begin opa = rb_reg; opb = rc_reg; end
            ST_RG: begin mode_sel = ENG_GCD; opa = ra_reg; opb = rb_reg; end
            ST_RN: begin mode_sel = ENG_DIV; opa = ra_reg; opb = rg_reg; end
            ST_RD: begin mode_sel = ENG_DIV; opa = rb_reg; opb = rg_reg; end
            default: ;
        endcase
    end

    // one engine step
    always_comb begin
        x_next   = x_reg;
        y_next   = y_reg;
        acc_next = acc_reg;
        cnt_next = cnt_reg;
        eng_done = 1'b0;
        eng_res  = acc_reg[X-1:0];
        rem_sh   = {acc_reg[X-1:0], x_reg[X-1]};
        ge       = rem_sh >= {1'b0, y_reg};
        case (eng_mode_reg)
            ENG_MUL: begin
                acc_next = y_reg[0] ? acc_reg + {1'b0, x_reg} : acc_reg;
                x_next   = x_reg << 1;
                y_next   = y_reg >> 1;
                cnt_next = cnt_reg - CW'(1);
                eng_done = eng_busy_reg && (cnt_reg == CW'(1));
                eng_res  = acc_next[X-1:0];
            end
            ENG_DIV: begin
                acc_next = ge ? rem_sh - {1'b0, y_reg} : rem_sh;
                x_next   = {x_reg[X-2:0], ge};
                cnt_next = cnt_reg - CW'(1);
                eng_done = eng_busy_reg && (cnt_reg == CW'(1));
                eng_res  = x_next;
            end
            ENG_GCD: begin
                eng_res = y_reg;
                if (x_reg != '0) begin
                    if (!x_reg[0] && !y_reg[0]) begin
                        x_next   = x_reg >> 1;
                        y_next   = y_reg >> 1;
                        cnt_next = cnt_reg + CW'(1);
                    end else if (!x_reg[0]) begin
                        x_next = x_reg >> 1;
                    end else if (!y_reg[0]) begin
                        y_next = y_reg >> 1;
                    end else if (x_reg >= y_reg) begin
                        x_next = x_reg - y_reg;
                    end else begin
                        y_next = y_reg - x_reg;
                    end
                end else if (cnt_reg != '0) begin
                    y_next   = y_reg << 1;
                    cnt_next = cnt_reg - CW'(1);
                end else begin
                    eng_done = eng_busy_reg;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            eng_busy_reg <= 1'b0;
        end else if (cmd.start) begin
            eng_busy_reg <= 1'b1;
        end else if (eng_done) begin
            eng_busy_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.start) begin
            eng_mode_reg <= mode_sel;
            step_reg     <= cmd.step;
            x_reg        <= opa;
            y_reg        <= opb;
            acc_reg      <= '0;
            case (mode_sel)
                ENG_MUL: cnt_reg <= CW'(M);
                ENG_DIV: cnt_reg <= CW'(X);
                default: cnt_reg <= '0;
            endcase
        end else if (eng_busy_reg) begin
            x_reg   <= x_next;
            y_reg   <= y_next;
            acc_reg <= acc_next;
            cnt_reg <= cnt_next;
        end
    end

    // combine step of add/subtract
    logic        l1, s2;
    logic [X-1:0] sum_v;
    logic         sum_neg;

    always_comb begin
        l1 = (sa_reg ^ sb_reg) && (ra_reg != '0);
        s2 = ((op_reg == OP_SUB) ? !(sc_reg ^ sd_reg) : (sc_reg ^ sd_reg))
             && (rc_reg != '0);
        if (l1 == s2) begin
            sum_v   = ra_reg + rc_reg;
            sum_neg = l1;
        end else if (ra_reg >= rc_reg) begin
            sum_v   = ra_reg - rc_reg;
            sum_neg = l1;
        end else begin
            sum_v   = rc_reg - ra_reg;
            sum_neg = s2;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_in) begin
            op_reg  <= in_op;
            sa_reg  <= in_a[W-1];
            sb_reg  <= in_b[W-1];
            sc_reg  <= in_c[W-1];
            sd_reg  <= in_d[W-1];
            neg_reg <= in_a[W-1] ^ in_b[W-1] ^ in_c[W-1] ^ in_d[W-1];
            ra_reg  <= X'(am);
            rb_reg  <= X'(bm);
            rc_reg  <= X'(cm);
            rd_reg  <= X'(dm);
        end else if (cmd.comb) begin
            ra_reg  <= sum_v;
            rb_reg  <= rb_reg;
            neg_reg <= sum_neg;
        end else if (eng_done) begin
            case (step_reg)
                ST_G1, ST_RG:        rg_reg <= eng_res;
                ST_Q1, ST_C1:        rp_reg <= eng_res;
                ST_Q2, ST_C2:        rq_reg <= eng_res;
                ST_T1, ST_P1, ST_RN: ra_reg <= eng_res;
                ST_T2:               rc_reg <= eng_res;
                ST_TL, ST_P2, ST_RD: rb_reg <= eng_res;
                default: ;
            endcase
        end
    end

    always_comb begin
        inv_in = (op_reg > OP_LT) || (rb_reg == '0) || (rd_reg == '0)
                 || ((op_reg == OP_DIV) && (rc_reg == '0));
        stat.eng_done  = eng_done;
        stat.is_cmp    = is_cmp;
        stat.is_addsub = (op_reg == OP_ADD) || (op_reg == OP_SUB);
        stat.invalid   = inv_in;
        stat.zero      = (ra_reg == '0);
    end

    // result formation
    logic signed [X:0] sp, sq;
    logic [LW-1:0]     ra_w, rb_w;
    logic              ovf, cmp_v;
    logic [NUM_W-1:0]  num_v;

    always_comb begin
        sp    = (sa_reg ^ sd_reg) ? -$signed({1'b0, rp_reg}) : $signed({1'b0, rp_reg});
        sq    = (sb_reg ^ sc_reg) ? -$signed({1'b0, rq_reg}) : $signed({1'b0, rq_reg});
        cmp_v = (op_reg == OP_GT) ? (sp > sq) : (sp < sq);
        ra_w  = LW'(ra_reg);
        rb_w  = LW'(rb_reg);
        ovf   = (rb_w > LW'(33'h0_7FFF_FFFF))
                || (ra_w > (neg_reg ? LW'(33'h0_8000_0000) : LW'(33'h0_7FFF_FFFF)));
        num_v = neg_reg ? (~ra_w[NUM_W-1:0] + NUM_W'(1)) : ra_w[NUM_W-1:0];
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_out) begin
            out_num    <= '0;
            out_den    <= '0;
            out_cmp    <= 1'b0;
            out_status <= STATUS_OK;
            if (is_cmp) begin
                out_cmp <= cmp_v;
            end else if (inv_in) begin
                out_status <= STATUS_INVALID;
            end else if (ra_reg == '0) begin
                out_den <= DEN_W'(1);
            end else if (ovf) begin
                out_status <= STATUS_OVERFLOW;
            end else begin
                out_num <= num_v;
                out_den <= rb_w[DEN_W-1:0];
            end
        end
    end

endmodule

`default_nettype wire

/* hw/rtl/rational_arithmetic_unit.sv */
// ----------------------------------------------------------------------------
// rational_arithmetic_unit
// Exact add/sub/mul/div/compare of two signed fractions, reduced by gcd.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                          | tuser
//  s_      | in  | left_num, left_den, right_num, right_den    | op
//  m_      | out | result_num, result_den, compare_true, status| -
//
//  One beat at a time; an item runs on a shared bit-serial engine
//  (shift-add multiply, restoring divide, binary gcd). A finished result
//  sits in the output register; the next beat is taken while it waits.
//  Synchronous active-low reset, no clearing pass.
// ----------------------------------------------------------------------------
`default_nettype none

module rational_arithmetic_unit
    import rau_pkg::*;
#(
    parameter int OPERAND_WIDTH = OPERAND_WIDTH_DEF,
    localparam int IN_TW = ((4 * OPERAND_WIDTH + 7) / 8) * 8
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             s_tvalid,
    output logic                  s_tready,
    // left_num, left_den, right_num, right_den
    input  wire logic [IN_TW-1:0] s_tdata,
    // op
    input  wire logic [OP_W-1:0]  s_tuser,
    output logic                  m_tvalid,
    input  wire logic             m_tready,
    // result_num, result_den, compare_true, status, zero pad
    output logic [OUT_TW-1:0]     m_tdata
);

    localparam int W = OPERAND_WIDTH;

    cmd_t                cmd;
    stat_t               stat;
    logic [NUM_W-1:0]    out_num;
    logic [DEN_W-1:0]    out_den;
    logic                out_cmp;
    logic [STATUS_W-1:0] out_status;

    rau_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd),
        .stat     (stat)
    );

    rau_dp #(.OPERAND_WIDTH(OPERAND_WIDTH)) u_dp (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .cmd        (cmd),
        .stat       (stat),
        .in_op      (s_tuser),
        .in_a       (s_tdata[W-1:0]),
        .in_b       (s_tdata[2*W-1:W]),
        .in_c       (s_tdata[3*W-1:2*W]),
        .in_d       (s_tdata[4*W-1:3*W]),
        .out_num    (out_num),
        .out_den    (out_den),
        .out_cmp    (out_cmp),
        .out_status (out_status)
    );

    assign m_tdata = {(OUT_TW - OUT_BITS)'(0), out_status, out_cmp, out_den, out_num};

endmodule

`default_nettype wire

/* hw/rtl/rau_checker.sv */
// ----------------------------------------------------------------------------
// rau_checker
// Port-level checks of the rational arithmetic unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

module rau_checker
    import rau_pkg::*;
(
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              s_tvalid,
    input wire logic              s_tready,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [OUT_TW-1:0] m_tdata
);

    logic [STATUS_W-1:0] st;
    logic                zero_frac;

    assign st        = m_tdata[OUT_BITS-1:OUT_BITS-STATUS_W];
    assign zero_frac = (m_tdata[NUM_W+DEN_W-1:0] == '0);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result beat changed while stalled");

    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (st == STATUS_OK) || (st == STATUS_INVALID)
                     || (st == STATUS_OVERFLOW))
        else $error("status code out of range");

    a_fail_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && (st != STATUS_OK) |-> zero_frac && !m_tdata[NUM_W+DEN_W])
        else $error("failed result carries data");

    a_cmp_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[NUM_W+DEN_W] |-> zero_frac && (st == STATUS_OK))
        else $error("comparison result carries a fraction");

    a_one_item: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> !s_tready)
        else $error("second beat taken while busy");

endmodule

bind rational_arithmetic_unit rau_checker u_rau_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);

`default_nettype wire
